// ----- rtl/sql_top_level_semicolon_counter_unit_macros.svh -----
// Assertion macros for the SQL semicolon counter checker.
`ifndef SQL_TOP_LEVEL_SEMICOLON_COUNTER_UNIT_MACROS_SVH
`define SQL_TOP_LEVEL_SEMICOLON_COUNTER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SQLSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sqlsc check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define SQLSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sqlsc check failed");

`endif

// ----- rtl/sqlsc_pkg.sv -----
// Shared types and constants of the SQL semicolon counter.
`default_nettype none
package sqlsc_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_WORD   = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_STRING = 3'd3,
    MODE_BLOCK  = 3'd4
  } scan_mode_e;

  typedef enum logic [1:0] {
    HELD_NONE  = 2'd0,
    HELD_DASH  = 2'd1,
    HELD_SLASH = 2'd2
  } held_e;

  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_BEGIN = 2'd1,
    PEND_END   = 2'd2
  } pend_e;

  localparam int unsigned WORD_KEEP = 6;

  // Keywords, upper case, packed right-aligned one byte per letter.
  localparam logic [47:0] KW_BEGIN  = 48'h00_42_45_47_49_4E;
  localparam logic [47:0] KW_END    = 48'h00_00_00_45_4E_44;
  localparam logic [47:0] KW_WORK   = 48'h00_00_57_4F_52_4B;
  localparam logic [47:0] KW_IF     = 48'h00_00_00_00_49_46;
  localparam logic [47:0] KW_WHILE  = 48'h00_57_48_49_4C_45;
  localparam logic [47:0] KW_LOOP   = 48'h00_00_4C_4F_4F_50;
  localparam logic [47:0] KW_REPEAT = 48'h52_45_50_45_41_54;
  localparam logic [47:0] KW_CASE   = 48'h00_00_43_41_53_45;

  localparam logic [2:0] LEN_BEGIN  = 3'd5;
  localparam logic [2:0] LEN_END    = 3'd3;
  localparam logic [2:0] LEN_WORK   = 3'd4;
  localparam logic [2:0] LEN_IF     = 3'd2;
  localparam logic [2:0] LEN_WHILE  = 3'd5;
  localparam logic [2:0] LEN_LOOP   = 3'd4;
  localparam logic [2:0] LEN_REPEAT = 3'd6;
  localparam logic [2:0] LEN_CASE   = 3'd4;

  // Byte after classification by the front end.
  typedef struct packed {
    logic [7:0] up;      // byte with a-z folded to upper case
    logic       alpha;
    logic       digit;
    logic       space;
    logic       under;
    logic       dash;
    logic       slash;
    logic       star;
    logic       hash;
    logic       quote;
    logic       semi;
    logic       nl;
    logic       last;
  } cls_t;

  typedef struct packed {
    logic [15:0] count;
    logic [7:0]  depth;
    logic        done;
  } res_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage
`default_nettype wire

// ----- rtl/sqlsc_fifo.sv -----
// Small flop-based queue used between the stages.
`default_nettype none
module sqlsc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire logic [WIDTH-1:0]      wdata_i,
  input  wire logic                  pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output sqlsc_pkg::fifo_stat_t      stat_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CW'(DEPTH));
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rdata_o      = mem_q[rp_q];

  always_comb begin
    wp_d = wp_q;
    rp_d = rp_q;
    if (do_push) begin
      wp_d = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (do_pop) begin
      rp_d = (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sqlsc_front.sv -----
// Front end: takes bytes and registers their character class.
`default_nettype none
module sqlsc_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  output logic                       full_o,
  input  wire logic [7:0]            text_byte_i,
  input  wire logic                  final_byte_i,
  input  wire sqlsc_pkg::fifo_stat_t mid_stat_i,
  output logic                       mid_push_o,
  output sqlsc_pkg::cls_t            cls_o
);

  sqlsc_pkg::cls_t cls_d, cls_q;
  logic            vld_q, vld_d;
  logic            accept, moved;
  logic            lower;

  assign full_o     = vld_q && mid_stat_i.full;
  assign accept     = push_i && !full_o;
  assign moved      = vld_q && !mid_stat_i.full;
  assign mid_push_o = vld_q;
  assign cls_o      = cls_q;

  always_comb begin
    lower       = (text_byte_i >= 8'd97) && (text_byte_i <= 8'd122);
    cls_d.up    = lower ? text_byte_i - 8'd32 : text_byte_i;
    cls_d.alpha = lower || ((text_byte_i >= 8'd65) && (text_byte_i <= 8'd90));
    cls_d.digit = (text_byte_i >= 8'd48) && (text_byte_i <= 8'd57);
    cls_d.space = (text_byte_i == 8'd32) || ((text_byte_i >= 8'd9) && (text_byte_i <= 8'd13));
    cls_d.under = (text_byte_i == 8'd95);
    cls_d.dash  = (text_byte_i == 8'd45);
    cls_d.slash = (text_byte_i == 8'd47);
    cls_d.star  = (text_byte_i == 8'd42);
    cls_d.hash  = (text_byte_i == 8'd35);
    cls_d.quote = (text_byte_i == 8'd39);
    cls_d.semi  = (text_byte_i == 8'd59);
    cls_d.nl    = (text_byte_i == 8'd10);
    cls_d.last  = final_byte_i;
  end

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (moved) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cls_q <= cls_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sqlsc_back.sv -----
// Back end: lexer state, keyword matching, depth and semicolon counting.
`default_nettype none
module sqlsc_back #(
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned DEPTH_MAX  = 255
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sqlsc_pkg::cls_t       cls_i,
  input  wire sqlsc_pkg::fifo_stat_t in_stat_i,
  output logic                       in_pop_o,
  input  wire sqlsc_pkg::fifo_stat_t out_stat_i,
  output logic                       out_push_o,
  output sqlsc_pkg::res_t            result_o
);

  localparam int unsigned DW = $clog2(DEPTH_MAX + 1);

  sqlsc_pkg::scan_mode_e  mode_q, mode_d, mode_n;
  sqlsc_pkg::held_e       held_q, held_d, held_n;
  sqlsc_pkg::pend_e       pend_q, pend_d, pend_n;
  logic                   star_q, star_d, star_n;
  logic [47:0]            let_q, let_d, let_n;
  logic [2:0]             len_q, len_d, len_n;
  logic                   long_q, long_d, long_n;
  logic [COUNT_BITS-1:0]  cnt_q, cnt_d, cnt_n;
  logic [DW-1:0]          dep_q, dep_d, dep_n;
  logic                   go, do_norm;
  logic [31:0]            cnt_wide;
  logic [15:0]            dep_wide;

  function automatic logic kw_is(logic [47:0] l, logic [2:0] n, logic lg,
                                 logic [47:0] kv, logic [2:0] kl);
    return !lg && (n == kl) && (l == kv);
  endfunction

  function automatic logic [DW-1:0] dep_up(logic [DW-1:0] d);
    return (d < DW'(DEPTH_MAX)) ? d + 1'b1 : d;
  endfunction

  function automatic logic [DW-1:0] dep_down(logic [DW-1:0] d);
    return (d != '0) ? d - 1'b1 : d;
  endfunction

  // Word just ended: resolve the keyword that was waiting for it.
  function automatic logic [DW-1:0] ew_depth(sqlsc_pkg::pend_e p, logic [47:0] l,
                                             logic [2:0] n, logic lg, logic [DW-1:0] d);
    logic [DW-1:0] r;
    r = d;
    if (p == sqlsc_pkg::PEND_BEGIN) begin
      if (!kw_is(l, n, lg, sqlsc_pkg::KW_WORK, sqlsc_pkg::LEN_WORK)) r = dep_up(d);
    end else if (p == sqlsc_pkg::PEND_END) begin
      if (!(kw_is(l, n, lg, sqlsc_pkg::KW_IF, sqlsc_pkg::LEN_IF) ||
            kw_is(l, n, lg, sqlsc_pkg::KW_WHILE, sqlsc_pkg::LEN_WHILE) ||
            kw_is(l, n, lg, sqlsc_pkg::KW_LOOP, sqlsc_pkg::LEN_LOOP) ||
            kw_is(l, n, lg, sqlsc_pkg::KW_REPEAT, sqlsc_pkg::LEN_REPEAT) ||
            kw_is(l, n, lg, sqlsc_pkg::KW_CASE, sqlsc_pkg::LEN_CASE))) r = dep_down(d);
    end
    return r;
  endfunction

  function automatic sqlsc_pkg::pend_e ew_pend(logic [47:0] l, logic [2:0] n, logic lg);
    sqlsc_pkg::pend_e r;
    r = sqlsc_pkg::PEND_NONE;
    if (kw_is(l, n, lg, sqlsc_pkg::KW_BEGIN, sqlsc_pkg::LEN_BEGIN)) begin
      r = sqlsc_pkg::PEND_BEGIN;
    end else if (kw_is(l, n, lg, sqlsc_pkg::KW_END, sqlsc_pkg::LEN_END)) begin
      r = sqlsc_pkg::PEND_END;
    end
    return r;
  endfunction

  assign go         = !in_stat_i.empty && !out_stat_i.full;
  assign in_pop_o   = go;
  assign out_push_o = go;

  // Next state, before the end-of-text clear.
  always_comb begin
    mode_n  = mode_q;
    held_n  = held_q;
    pend_n  = pend_q;
    star_n  = star_q;
    let_n   = let_q;
    len_n   = len_q;
    long_n  = long_q;
    cnt_n   = cnt_q;
    dep_n   = dep_q;
    do_norm = 1'b0;

    if (held_q != sqlsc_pkg::HELD_NONE) begin
      held_n = sqlsc_pkg::HELD_NONE;
      if (held_q == sqlsc_pkg::HELD_DASH && cls_i.dash) begin
        mode_n = sqlsc_pkg::MODE_LINE;
      end else if (held_q == sqlsc_pkg::HELD_SLASH && cls_i.star) begin
        mode_n = sqlsc_pkg::MODE_BLOCK;
        star_n = 1'b0;
      end else begin
        do_norm = 1'b1;
      end
    end else begin
      case (mode_q)
        sqlsc_pkg::MODE_WORD: begin
          if (cls_i.alpha || cls_i.digit || cls_i.under) begin
            if (len_q < 3'(sqlsc_pkg::WORD_KEEP)) begin
              let_n = {let_q[39:0], cls_i.up};
              len_n = len_q + 1'b1;
            end else begin
              long_n = 1'b1;
            end
          end else begin
            dep_n   = ew_depth(pend_q, let_q, len_q, long_q, dep_q);
            pend_n  = ew_pend(let_q, len_q, long_q);
            mode_n  = sqlsc_pkg::MODE_NORMAL;
            do_norm = 1'b1;
          end
        end
        sqlsc_pkg::MODE_LINE: begin
          if (cls_i.nl) mode_n = sqlsc_pkg::MODE_NORMAL;
        end
        sqlsc_pkg::MODE_STRING: begin
          if (cls_i.quote) mode_n = sqlsc_pkg::MODE_NORMAL;
        end
        sqlsc_pkg::MODE_BLOCK: begin
          if (star_q && cls_i.slash) begin
            mode_n = sqlsc_pkg::MODE_NORMAL;
            star_n = 1'b0;
          end else if (cls_i.last) begin
            // unclosed comment: last byte is scanned as plain text
            mode_n  = sqlsc_pkg::MODE_NORMAL;
            star_n  = 1'b0;
            do_norm = 1'b1;
          end else begin
            star_n = cls_i.star;
          end
        end
        default: begin
          mode_n  = sqlsc_pkg::MODE_NORMAL;
          do_norm = 1'b1;
        end
      endcase
    end

    if (do_norm) begin
      // look-ahead after BEGIN / END
      if (pend_n != sqlsc_pkg::PEND_NONE && !cls_i.space) begin
        if (pend_n == sqlsc_pkg::PEND_BEGIN) begin
          if (!cls_i.alpha) begin
            if (!cls_i.semi) dep_n = dep_up(dep_n);
            pend_n = sqlsc_pkg::PEND_NONE;
          end
        end else if (!(cls_i.alpha || cls_i.under)) begin
          dep_n  = dep_down(dep_n);
          pend_n = sqlsc_pkg::PEND_NONE;
        end
      end
      if (cls_i.dash) begin
        held_n = sqlsc_pkg::HELD_DASH;
      end else if (cls_i.slash) begin
        held_n = sqlsc_pkg::HELD_SLASH;
      end else if (cls_i.hash) begin
        mode_n = sqlsc_pkg::MODE_LINE;
      end else if (cls_i.quote) begin
        mode_n = sqlsc_pkg::MODE_STRING;
      end else if (cls_i.alpha || cls_i.under) begin
        mode_n = sqlsc_pkg::MODE_WORD;
        let_n  = {40'd0, cls_i.up};
        len_n  = 3'd1;
        long_n = 1'b0;
      end else if (cls_i.semi) begin
        if (dep_n == '0 && cnt_n != '1) cnt_n = cnt_n + 1'b1;
      end
    end

    if (cls_i.last) begin
      if (mode_n == sqlsc_pkg::MODE_WORD) begin
        dep_n  = ew_depth(pend_n, let_n, len_n, long_n, dep_n);
        pend_n = ew_pend(let_n, len_n, long_n);
      end
      if (pend_n == sqlsc_pkg::PEND_END) dep_n = dep_down(dep_n);
      pend_n = sqlsc_pkg::PEND_NONE;
    end
  end

  // Register inputs: everything clears after the last byte.
  always_comb begin
    if (cls_i.last) begin
      mode_d = sqlsc_pkg::MODE_NORMAL;
      held_d = sqlsc_pkg::HELD_NONE;
      pend_d = sqlsc_pkg::PEND_NONE;
      star_d = 1'b0;
      let_d  = '0;
      len_d  = '0;
      long_d = 1'b0;
      cnt_d  = '0;
      dep_d  = '0;
    end else begin
      mode_d = mode_n;
      held_d = held_n;
      pend_d = pend_n;
      star_d = star_n;
      let_d  = let_n;
      len_d  = len_n;
      long_d = long_n;
      cnt_d  = cnt_n;
      dep_d  = dep_n;
    end
  end

  // Result request.
  always_comb begin
    cnt_wide       = 32'(cnt_n);
    dep_wide       = 16'(dep_n);
    result_o.count = cnt_wide[15:0];
    result_o.depth = dep_wide[7:0];
    result_o.done  = cls_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= sqlsc_pkg::MODE_NORMAL;
      held_q <= sqlsc_pkg::HELD_NONE;
      pend_q <= sqlsc_pkg::PEND_NONE;
      star_q <= 1'b0;
      let_q  <= '0;
      len_q  <= '0;
      long_q <= 1'b0;
      cnt_q  <= '0;
      dep_q  <= '0;
    end else if (go) begin
      mode_q <= mode_d;
      held_q <= held_d;
      pend_q <= pend_d;
      star_q <= star_d;
      let_q  <= let_d;
      len_q  <= len_d;
      long_q <= long_d;
      cnt_q  <= cnt_d;
      dep_q  <= dep_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sql_top_level_semicolon_counter_unit.sv -----
// Path: an accepted byte is registered in the front end, queued, scanned by the back end and queued as a result.
// Throughput: one byte per cycle while no queue is full; the back end updates all scan state for each byte it moves.
// A two-entry queue between front and back, and one on the result side, absorb stalls.
// Reset (rst_ni low, asynchronous) empties the queues and clears all scan state.
// State also clears after each byte marked final.
`default_nettype none
module sql_top_level_semicolon_counter_unit #(
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned DEPTH_MAX  = 255
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  text_byte_i,
  input  wire logic        final_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      statement_count_o,
  output logic [7:0]       block_depth_o,
  output logic             text_done_o
);

  sqlsc_pkg::cls_t       cls_f, cls_b;
  sqlsc_pkg::fifo_stat_t mid_stat, out_stat;
  sqlsc_pkg::res_t       res_b, res_o;
  logic                  mid_push, mid_pop, out_push;

  sqlsc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .text_byte_i  (text_byte_i),
    .final_byte_i (final_byte_i),
    .mid_stat_i   (mid_stat),
    .mid_push_o   (mid_push),
    .cls_o        (cls_f)
  );

  sqlsc_fifo #(
    .WIDTH ($bits(sqlsc_pkg::cls_t)),
    .DEPTH (2)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (cls_f),
    .pop_i   (mid_pop),
    .rdata_o (cls_b),
    .stat_o  (mid_stat)
  );

  sqlsc_back #(
    .COUNT_BITS (COUNT_BITS),
    .DEPTH_MAX  (DEPTH_MAX)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cls_i      (cls_b),
    .in_stat_i  (mid_stat),
    .in_pop_o   (mid_pop),
    .out_stat_i (out_stat),
    .out_push_o (out_push),
    .result_o   (res_b)
  );

  sqlsc_fifo #(
    .WIDTH ($bits(sqlsc_pkg::res_t)),
    .DEPTH (2)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (res_b),
    .pop_i   (pop),
    .rdata_o (res_o),
    .stat_o  (out_stat)
  );

  assign empty             = out_stat.empty;
  assign statement_count_o = res_o.count;
  assign block_depth_o     = res_o.depth;
  assign text_done_o       = res_o.done;

endmodule
`default_nettype wire

// ----- rtl/sqlsc_checker.sv -----
// Port-level checks for the SQL semicolon counter, bound to the top level.
`default_nettype none
`include "sql_top_level_semicolon_counter_unit_macros.svh"
module sqlsc_checker #(
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned DEPTH_MAX  = 255
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        push,
  input wire logic        full,
  input wire logic [7:0]  text_byte_i,
  input wire logic        final_byte_i,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [15:0] statement_count_o,
  input wire logic [7:0]  block_depth_o,
  input wire logic        text_done_o
);

  // a waiting result is not dropped
  `SQLSC_ASSERT_NXT(a_res_kept, !empty && !pop, !empty)
  // a waiting result holds its value
  `SQLSC_ASSERT_NXT(a_res_stable, !empty && !pop,
    $stable(statement_count_o) && $stable(block_depth_o) && $stable(text_done_o))
  // depth never exceeds its limit
  `SQLSC_ASSERT_IMP(a_depth_max, !empty && DEPTH_MAX < 256,
    32'(block_depth_o) <= DEPTH_MAX)
  // within one text the count does not go down
  `SQLSC_ASSERT_NXT(a_count_mono, !empty && pop && !text_done_o && COUNT_BITS <= 16,
    empty || statement_count_o >= $past(statement_count_o))

endmodule

bind sql_top_level_semicolon_counter_unit sqlsc_checker #(
  .COUNT_BITS (COUNT_BITS),
  .DEPTH_MAX  (DEPTH_MAX)
) u_sqlsc_checker (.*);
`default_nettype wire
